// ===== design/postfix_expression_evaluator_top_macros.svh =====
// ---------------------------------------------------------------------------
// Postfix expression evaluator assertion macros
// Concurrent assertion wrappers used by the evaluator's top-level RTL file.
// ---------------------------------------------------------------------------
`ifndef POSTFIX_EXPRESSION_EVALUATOR_TOP_MACROS_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
`define PEXP_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");
`define PEXP_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define PEXP_ASSERT_SAME(lbl, ante, cons)
`define PEXP_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== design/pexp_pkg.sv =====
// ---------------------------------------------------------------------------
// Postfix expression evaluator package
// Shared types, character codes and sizes of the stack calculator.
// ---------------------------------------------------------------------------
package pexp_pkg;

   localparam int STACK_DEPTH = 16;
   localparam int CNT_W = $clog2(STACK_DEPTH + 1);
   localparam int IDX_W = $clog2(STACK_DEPTH);

   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_MUL   = 8'h2A;
   localparam logic [7:0] CH_DIV   = 8'h2F;
   localparam logic [7:0] CH_ADD   = 8'h2B;
   localparam logic [7:0] CH_SUB   = 8'h2D;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_UNDERFLOW = 2'd1,
      ST_DIVZERO   = 2'd2,
      ST_OVERFLOW  = 2'd3
   } status_code_type;

   typedef enum logic [2:0] {
      CLS_NUM_DIGIT = 3'd0,
      CLS_NUM_END   = 3'd1,
      CLS_OPERATOR  = 3'd2,
      CLS_SPACE     = 3'd3,
      CLS_LITERAL   = 3'd4
   } sym_class_type;

   typedef struct packed {
      logic [7:0] symbol;
      logic       is_last;
   } req_item_type;

   typedef struct packed {
      logic signed [31:0] value;
      status_code_type    status;
   } rsp_item_type;

   typedef struct packed {
      logic capture;
      logic acc_step;
      logic start_num;
      logic push_acc;
      logic push_char;
      logic op_under;
      logic rd_top;
      logic rd_second;
      logic exec;
      logic div_start;
      logic div_take;
      logic push_res;
      logic emit;
   } dp_cmd_type;

   typedef struct packed {
      sym_class_type sym_class;
      logic          count_lt2;
      logic          is_last;
      logic          op_is_div;
      logic          divisor_zero;
      logic          div_done;
   } dp_status_type;

endpackage

// ===== design/pexp_div.sv =====
// ---------------------------------------------------------------------------
// Postfix expression evaluator divider
// Radix-2 restoring divider on magnitudes with truncation toward zero.
// ---------------------------------------------------------------------------
module pexp_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [31:0] quotient
);
   logic [31:0] quo_ff, quo_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] mag_ff, mag_in;
   logic        neg_ff, neg_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [32:0] trial;
   logic        fits;

   always_comb begin
      trial = {rem_ff, quo_ff[31]};
      fits = trial >= {1'b0, mag_ff};
      quo_in = quo_ff;
      rem_in = rem_ff;
      mag_in = mag_ff;
      neg_in = neg_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         quo_in = dividend[31] ? 32'd0 - dividend : dividend;
         mag_in = divisor[31] ? 32'd0 - divisor : divisor;
         neg_in = dividend[31] ^ divisor[31];
         rem_in = '0;
         cnt_in = '0;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         rem_in = fits ? 32'(trial - {1'b0, mag_ff}) : trial[31:0];
         quo_in = {quo_ff[30:0], fits};
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      mag_ff <= mag_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quotient = neg_ff ? 32'd0 - quo_ff : quo_ff;

endmodule

// ===== design/pexp_dp.sv =====
// ---------------------------------------------------------------------------
// Postfix expression evaluator datapath
// Operand stack, number accumulator, arithmetic and result register.
// ---------------------------------------------------------------------------
module pexp_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  pexp_pkg::req_item_type req_payload,
   input  pexp_pkg::dp_cmd_type   cmd,
   output pexp_pkg::dp_status_type status,
   output pexp_pkg::rsp_item_type rsp_payload
);
   import pexp_pkg::*;

   logic [31:0]     mem [STACK_DEPTH];
   req_item_type    item_ff;
   logic            in_number_ff, in_number_in;
   logic [31:0]     acc_ff, acc_in;
   logic [CNT_W-1:0] count_ff, count_in;
   status_code_type err_ff, err_in;
   logic [31:0]     t1_ff;
   logic [31:0]     rd_data_ff;
   logic [31:0]     res_ff;
   rsp_item_type    rsp_ff;

   logic [31:0]     char_val;
   logic [31:0]     acc_next;
   logic [31:0]     push_val;
   logic            push_en;
   logic            full;
   logic            rd_en;
   logic [CNT_W-1:0] rd_ptr;
   logic [31:0]     exec_val;
   logic            div_done;
   logic [31:0]     div_q;
   logic            is_op;

   pexp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (rd_data_ff),
      .divisor  (t1_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   always_comb begin
      char_val = {24'd0, item_ff.symbol} - {24'd0, CH_ZERO};
      acc_next = (acc_ff << 3) + (acc_ff << 1) + char_val;
      full = count_ff >= CNT_W'(STACK_DEPTH);
      push_en = cmd.push_acc | cmd.push_char | cmd.push_res;
      if (cmd.push_acc) begin
         push_val = acc_ff;
      end else if (cmd.push_char) begin
         push_val = char_val;
      end else begin
         push_val = res_ff;
      end
      rd_en = cmd.rd_top | cmd.rd_second;
      rd_ptr = count_ff - (cmd.rd_second ? CNT_W'(2) : CNT_W'(1));
      case (item_ff.symbol)
         CH_MUL:  exec_val = rd_data_ff * t1_ff;
         CH_DIV:  exec_val = '0;
         CH_ADD:  exec_val = rd_data_ff + t1_ff;
         default: exec_val = rd_data_ff - t1_ff;
      endcase
      is_op = (item_ff.symbol == CH_MUL) || (item_ff.symbol == CH_DIV) ||
              (item_ff.symbol == CH_ADD) || (item_ff.symbol == CH_SUB);
   end

   always_comb begin
      count_in = count_ff;
      acc_in = acc_ff;
      in_number_in = in_number_ff;
      err_in = err_ff;
      if (cmd.acc_step) begin
         acc_in = acc_next;
      end
      if (cmd.start_num) begin
         acc_in = '0;
         in_number_in = 1'b1;
      end
      if (cmd.push_acc) begin
         in_number_in = 1'b0;
      end
      if (push_en) begin
         if (full) begin
            if (err_ff == ST_OK) begin
               err_in = ST_OVERFLOW;
            end
         end else begin
            count_in = count_ff + CNT_W'(1);
         end
      end
      if (cmd.op_under) begin
         count_in = '0;
         if (err_ff == ST_OK) begin
            err_in = ST_UNDERFLOW;
         end
      end
      if (cmd.exec) begin
         count_in = count_ff - CNT_W'(2);
         if (item_ff.symbol == CH_DIV && t1_ff == 32'd0 && err_ff == ST_OK) begin
            err_in = ST_DIVZERO;
         end
      end
      if (cmd.emit) begin
         count_in = '0;
         acc_in = '0;
         in_number_in = 1'b0;
         err_in = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         acc_ff <= '0;
         in_number_ff <= 1'b0;
         err_ff <= ST_OK;
      end else begin
         count_ff <= count_in;
         acc_ff <= acc_in;
         in_number_ff <= in_number_in;
         err_ff <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_en && !full) begin
         mem[count_ff[IDX_W-1:0]] <= push_val;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_ptr[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_ff <= req_payload;
      end
      if (cmd.rd_second) begin
         t1_ff <= rd_data_ff;
      end
      if (cmd.exec) begin
         res_ff <= exec_val;
      end else if (cmd.div_take) begin
         res_ff <= div_q;
      end
      if (cmd.emit) begin
         rsp_ff.value <= (count_ff != '0) ? rd_data_ff : 32'd0;
         if (err_ff != ST_OK) begin
            rsp_ff.status <= err_ff;
         end else if (count_ff == '0) begin
            rsp_ff.status <= ST_UNDERFLOW;
         end else begin
            rsp_ff.status <= ST_OK;
         end
      end
   end

   always_comb begin
      if (in_number_ff) begin
         status.sym_class = (item_ff.symbol == CH_COMMA) ? CLS_NUM_END : CLS_NUM_DIGIT;
      end else if (is_op) begin
         status.sym_class = CLS_OPERATOR;
      end else if (item_ff.symbol == CH_SPACE) begin
         status.sym_class = CLS_SPACE;
      end else begin
         status.sym_class = CLS_LITERAL;
      end
      status.count_lt2 = count_ff < CNT_W'(2);
      status.is_last = item_ff.is_last;
      status.op_is_div = item_ff.symbol == CH_DIV;
      status.divisor_zero = t1_ff == 32'd0;
      status.div_done = div_done;
   end

   assign rsp_payload = rsp_ff;

endmodule

// ===== design/pexp_ctrl.sv =====
// ---------------------------------------------------------------------------
// Postfix expression evaluator controller
// Sequences decode, stack access, arithmetic and result hand-off per item.
// ---------------------------------------------------------------------------
module pexp_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  pexp_pkg::dp_status_type status,
   output pexp_pkg::dp_cmd_type    cmd
);
   import pexp_pkg::*;

   typedef enum logic [7:0] {
      S_IDLE      = 8'b0000_0001,
      S_DECODE    = 8'b0000_0010,
      S_RD_SECOND = 8'b0000_0100,
      S_EXEC      = 8'b0000_1000,
      S_DIV       = 8'b0001_0000,
      S_PUSH_RES  = 8'b0010_0000,
      S_FINISH    = 8'b0100_0000,
      S_EMIT      = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_FINISH;
            unique case (status.sym_class)
               CLS_NUM_DIGIT: cmd.acc_step = 1'b1;
               CLS_NUM_END:   cmd.push_acc = 1'b1;
               CLS_SPACE:     cmd.start_num = 1'b1;
               CLS_LITERAL:   cmd.push_char = 1'b1;
               CLS_OPERATOR: begin
                  if (status.count_lt2) begin
                     cmd.op_under = 1'b1;
                  end else begin
                     cmd.rd_top = 1'b1;
                     state_in = S_RD_SECOND;
                  end
               end
               default: state_in = S_FINISH;
            endcase
         end
         S_RD_SECOND: begin
            cmd.rd_second = 1'b1;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            if (status.op_is_div && !status.divisor_zero) begin
               cmd.div_start = 1'b1;
               state_in = S_DIV;
            end else begin
               state_in = S_PUSH_RES;
            end
         end
         S_DIV: begin
            if (status.div_done) begin
               cmd.div_take = 1'b1;
               state_in = S_PUSH_RES;
            end
         end
         S_PUSH_RES: begin
            cmd.push_res = 1'b1;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (status.is_last) begin
               cmd.rd_top = 1'b1;
               state_in = S_EMIT;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== design/postfix_expression_evaluator_top.sv =====
// ---------------------------------------------------------------------------
// Postfix expression evaluator
// Stack calculator that evaluates a postfix expression one byte per transfer.
//
// The req channel carries one expression byte and an is_last flag per
// transfer. After the transfer flagged is_last, one result (top of stack and
// a status code) leaves on the rsp channel; other transfers produce none.
// Digits, spaces, commas and literals pass from idle through decode and
// finish; * + - operators add second read, execute and push states, and a
// division by a nonzero divisor waits before push for the radix-2 divider,
// which retires one quotient bit per cycle. The last item goes from finish
// to an emit state that loads the top of stack and a status code into the
// output register and returns to idle as the result becomes valid.
// The stack is a 16-entry memory with one write and one registered read per
// cycle. Reset empties the stack, clears the error code and drops any pending
// result; no clearing pass is needed. While the receiver stalls, the result
// waits in the output register and further bytes are still accepted; a
// following last byte holds the block, and no byte is accepted, until the
// pending result has been transferred.
// ---------------------------------------------------------------------------
`include "postfix_expression_evaluator_top_macros.svh"

module postfix_expression_evaluator_top (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  pexp_pkg::req_item_type req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output pexp_pkg::rsp_item_type rsp_payload
);
   import pexp_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   pexp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   pexp_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_payload (rsp_payload)
   );

   `PEXP_ASSERT_NEXT(a_emit_shows_result, cmd.emit, rsp_valid)
   `PEXP_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready)
   `PEXP_ASSERT_NEXT(a_div_not_done_at_start, cmd.div_start, !status.div_done)
   `PEXP_ASSERT_SAME(a_result_from_emit, $rose(rsp_valid), $past(cmd.emit))

endmodule
